### rtl/core/versatile_interface_adapter_assert.svh
// Assertion macros used by the interface adapter top level.
// Depends on nothing; included by files that carry assertions.
`ifndef VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH
`define VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH

// Implication checked every edge outside reset.
`define VIA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define VIA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/via_pkg.sv
// Package for the interface adapter: item kinds, register offsets, flag bits, item and result types.
// Depends on nothing.
package via_pkg;
	localparam logic [3:0] K_READ = 4'd0;
	localparam logic [3:0] K_WRITE = 4'd1;
	localparam logic [3:0] K_TICK = 4'd2;
	localparam logic [3:0] K_PA = 4'd3;
	localparam logic [3:0] K_PB = 4'd4;
	localparam logic [3:0] K_CA1 = 4'd5;
	localparam logic [3:0] K_CA2 = 4'd6;
	localparam logic [3:0] K_CB1 = 4'd7;
	localparam logic [3:0] K_CB2 = 4'd8;

	localparam logic [3:0] R_ORB = 4'd0;
	localparam logic [3:0] R_ORA = 4'd1;
	localparam logic [3:0] R_DDRB = 4'd2;
	localparam logic [3:0] R_DDRA = 4'd3;
	localparam logic [3:0] R_T1CL = 4'd4;
	localparam logic [3:0] R_T1CH = 4'd5;
	localparam logic [3:0] R_T1LL = 4'd6;
	localparam logic [3:0] R_T1LH = 4'd7;
	localparam logic [3:0] R_T2CL = 4'd8;
	localparam logic [3:0] R_T2CH = 4'd9;
	localparam logic [3:0] R_SR = 4'd10;
	localparam logic [3:0] R_ACR = 4'd11;
	localparam logic [3:0] R_PCR = 4'd12;
	localparam logic [3:0] R_IFR = 4'd13;
	localparam logic [3:0] R_IER = 4'd14;
	localparam logic [3:0] R_ORANH = 4'd15;

	localparam logic [6:0] F_CA2 = 7'h01;
	localparam logic [6:0] F_CA1 = 7'h02;
	localparam logic [6:0] F_CB2 = 7'h08;
	localparam logic [6:0] F_CB1 = 7'h10;
	localparam logic [6:0] F_T2 = 7'h20;
	localparam logic [6:0] F_T1 = 7'h40;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] reg_offset;
		logic [7:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic irq;
		logic [7:0] port_a_out;
		logic [7:0] port_b_out;
		logic ca2_level;
		logic cb2_level;
	} result_t;
endpackage

### rtl/core/versatile_interface_adapter.sv
// 6522-style interface adapter: one bus access, timer tick or pin update per
// transfer, each answered with one result transfer.
//
// Rate: an item is worked on in via_core between the input register and the
// result register; a new item is accepted every clock while the result side
// takes each result, for a sustained rate of one item per cycle. The result
// register frees as it drains, so a finished result waiting on out_stall
// still blocks only when a further one is ready.
// Depends on via_pkg, via_core and versatile_interface_adapter_assert.svh.
`include "versatile_interface_adapter_assert.svh"
module versatile_interface_adapter (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [3:0] kind,
	input logic [3:0] reg_offset,
	input logic [7:0] value,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] read_data,
	output logic irq,
	output logic [7:0] port_a_out,
	output logic [7:0] port_b_out,
	output logic ca2_level,
	output logic cb2_level
);
	import via_pkg::*;

	item_t item_s1;
	logic vld_s1, vld_s2, adv;
	result_t res, res_s2;

	// Stage 1 advances into stage 2 when stage 2 is empty or draining.
	assign adv = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!in_stall) vld_s1 <= in_valid;
			if (adv) vld_s2 <= vld_s1;
		end
	end

	// Hold the input register while stage 1 is blocked.
	always_ff @(posedge clk) begin
		if (!in_stall) item_s1 <= '{kind: kind, reg_offset: reg_offset, value: value};
		if (adv && vld_s1) res_s2 <= res;
	end

	via_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(vld_s1 && adv),
		.item(item_s1),
		.res(res)
	);

	assign out_valid = vld_s2;
	assign read_data = res_s2.read_data;
	assign irq = res_s2.irq;
	assign port_a_out = res_s2.port_a_out;
	assign port_b_out = res_s2.port_b_out;
	assign ca2_level = res_s2.ca2_level;
	assign cb2_level = res_s2.cb2_level;

	`VIA_ASSERT_IMP(a_stall_only_full, clk, arst_n, in_stall, vld_s1 && vld_s2)
	`VIA_ASSERT_NXT(a_hold_result, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(read_data))
	`VIA_ASSERT_NXT(a_fill, clk, arst_n, vld_s1 && adv, out_valid)
endmodule

### rtl/core/via_core.sv
// Register file and item execution of the interface adapter.
// Depends on via_pkg; one item is executed per enable.
module via_core (
	input logic clk,
	input logic arst_n,
	input logic en,
	input via_pkg::item_t item,
	output via_pkg::result_t res
);
	import via_pkg::*;

	logic [7:0] dir_a_q, dir_b_q, ora_q, orb_q, pins_a_q, pins_b_q;
	logic [3:0] cin_q;
	logic [1:0] cout_q;
	logic [15:0] t1l_q, t1c_q, t2c_q;
	logic t1r_q, t2r_q;
	logic [7:0] t2ll_q, sr_q, pcr_q, acr_q, ifr_q;
	logic [6:0] ier_q;

	logic [7:0] dir_a_d, dir_b_d, ora_d, orb_d, pins_a_d, pins_b_d;
	logic [3:0] cin_d;
	logic [1:0] cout_d;
	logic [15:0] t1l_d, t1c_d, t2c_d;
	logic t1r_d, t2r_d;
	logic [7:0] t2ll_d, sr_d, pcr_d, acr_d, rd;
	logic [6:0] ier_d, fl, setf, clrf;
	logic anyf, lvl, oldl;

	always_comb begin
		dir_a_d = dir_a_q; dir_b_d = dir_b_q; ora_d = ora_q; orb_d = orb_q;
		pins_a_d = pins_a_q; pins_b_d = pins_b_q; cin_d = cin_q; cout_d = cout_q;
		t1l_d = t1l_q; t1c_d = t1c_q; t2c_d = t2c_q; t1r_d = t1r_q; t2r_d = t2r_q;
		t2ll_d = t2ll_q; sr_d = sr_q; pcr_d = pcr_q; acr_d = acr_q; ier_d = ier_q;
		fl = ifr_q[6:0];
		anyf = ifr_q[7];
		setf = '0; clrf = '0;
		rd = '0;
		lvl = item.value[0];
		oldl = 1'b0;
		unique case (item.kind)
			K_READ: begin
				unique case (item.reg_offset)
					R_ORB: begin
						clrf = F_CB1 | (((pcr_q & 8'ha0) == 8'h20) ? 7'h0 : F_CB2);
						rd = (orb_q & (acr_q[7] ? (dir_b_q | 8'h80) : dir_b_q))
							| (pins_b_q & ~(acr_q[7] ? (dir_b_q | 8'h80) : dir_b_q));
					end
					R_ORA: begin
						rd = dir_a_q | (pins_a_q & ~dir_a_q);
						clrf = F_CA1 | (((pcr_q & 8'h0a) == 8'h02) ? 7'h0 : F_CA2);
						if ((pcr_q & 8'h0c) == 8'h08) cout_d[0] = 1'b0;
					end
					R_DDRB: rd = dir_b_q;
					R_DDRA: rd = dir_a_q;
					R_T1CL: begin clrf = F_T1; rd = t1c_q[7:0]; end
					R_T1CH: rd = t1c_q[15:8];
					R_T1LL: rd = t1l_q[7:0];
					R_T1LH: rd = t1l_q[15:8];
					R_T2CL: begin clrf = F_T2; rd = t2c_q[7:0]; end
					R_T2CH: rd = t2c_q[15:8];
					R_SR: rd = sr_q;
					R_ACR: rd = acr_q;
					R_PCR: rd = pcr_q;
					R_IFR: rd = ifr_q;
					R_IER: rd = {1'b1, ier_q};
					R_ORANH: rd = dir_a_q | (pins_a_q & ~dir_a_q);
					default: rd = '0;
				endcase
			end
			K_WRITE: begin
				unique case (item.reg_offset)
					R_ORB: begin
						orb_d = acr_q[7] ? {orb_q[7], item.value[6:0]} : item.value;
						clrf = F_CB1 | (((pcr_q & 8'ha0) == 8'h20) ? 7'h0 : F_CB2);
						if ((pcr_q & 8'hc0) == 8'h80) cout_d[1] = 1'b0;
					end
					R_ORA: begin
						ora_d = item.value;
						clrf = F_CA1 | (((pcr_q & 8'h0a) == 8'h02) ? 7'h0 : F_CA2);
						if ((pcr_q & 8'h0e) == 8'h0a) cout_d[0] = 1'b1;
						else if ((pcr_q & 8'h0c) == 8'h08) cout_d[0] = 1'b0;
					end
					R_DDRB: dir_b_d = item.value;
					R_DDRA: dir_a_d = item.value;
					R_T1CL, R_T1LL: t1l_d[7:0] = item.value;
					R_T1LH: begin t1l_d[15:8] = item.value; clrf = F_T1; end
					R_T1CH: begin
						t1l_d[15:8] = item.value;
						t1c_d = {item.value, t1l_q[7:0]};
						clrf = F_T1;
						if (acr_q[7]) orb_d[7] = 1'b0;
						t1r_d = 1'b1;
					end
					R_T2CL: t2ll_d = item.value;
					R_T2CH: begin
						t2c_d = {item.value, t2ll_q};
						clrf = F_T2;
						if (acr_q[5]) t2r_d = 1'b0;
						else if ({item.value, t2ll_q} != 16'h0) t2r_d = 1'b1;
						else begin t2r_d = 1'b0; t2c_d = 16'hffff; end
					end
					R_SR: sr_d = item.value;
					R_ACR: begin
						acr_d = item.value;
						if (item.value[7]) orb_d[7] = ~t1r_q;
						if (item.value[6]) t1r_d = 1'b1;
					end
					R_PCR: begin
						pcr_d = item.value;
						if (item.value[3:2] == 2'b11) cout_d[0] = item.value[1];
						if (item.value[7:6] == 2'b11) cout_d[1] = item.value[5];
					end
					R_IFR: clrf = item.value[7] ? 7'h7f : item.value[6:0];
					R_IER: ier_d = item.value[7] ? (ier_q | item.value[6:0])
						: (ier_q & ~item.value[6:0]);
					R_ORANH: ora_d = item.value;
					default: ora_d = ora_q;
				endcase
			end
			K_TICK: begin
				if (t1r_q && t1c_q <= 16'd1) begin
					if (acr_q[6]) begin
						if (acr_q[7]) orb_d[7] = ~orb_q[7];
						t1c_d = t1l_q;
					end else begin
						if (acr_q[7]) orb_d[7] = 1'b1;
						t1r_d = 1'b0;
						t1c_d = 16'hffff;
					end
					setf = setf | F_T1;
				end else begin
					t1c_d = t1c_q - 16'd1;
				end
				if (!acr_q[5]) begin
					if (t2r_q && t2c_q <= 16'd1) begin
						t2r_d = 1'b0;
						t2c_d = 16'hffff;
						setf = setf | F_T2;
					end else begin
						t2c_d = t2c_q - 16'd1;
					end
				end
			end
			K_PA: pins_a_d = item.value;
			K_PB: begin
				pins_b_d = item.value;
				if (acr_q[5] && t2c_q != 16'h0 && pins_b_q[6] && !item.value[6]) begin
					t2c_d = t2c_q - 16'd1;
					if (t2c_q == 16'd1) setf = F_T2;
				end
			end
			K_CA1, K_CB1: begin
				oldl = (item.kind == K_CA1) ? cin_q[0] : cin_q[2];
				if (lvl != oldl) begin
					if (item.kind == K_CA1) begin
						cin_d[0] = lvl;
						if (lvl == pcr_q[0]) begin
							setf = F_CA1;
							if ((pcr_q & 8'h0c) == 8'h08) cout_d[0] = 1'b1;
						end
					end else begin
						cin_d[2] = lvl;
						if (lvl == pcr_q[4]) begin
							setf = F_CB1;
							if ((pcr_q & 8'hc0) == 8'h80) cout_d[1] = 1'b1;
						end
					end
				end
			end
			K_CA2: begin
				if (!pcr_q[3] && lvl != cin_q[1]) begin
					cin_d[1] = lvl;
					if (lvl == pcr_q[2]) setf = F_CA2;
				end
			end
			K_CB2: begin
				if (!pcr_q[7] && lvl != cin_q[3]) begin
					cin_d[3] = lvl;
					if (lvl == pcr_q[6]) setf = F_CB2;
				end
			end
			default: rd = '0;
		endcase
		// Apply flag clears/sets, then refresh the summary bit.
		if (clrf != 7'h0 || (item.kind == K_WRITE && item.reg_offset == R_IFR)) begin
			fl = fl & ~clrf;
			anyf = |(fl & ier_q);
		end
		if (setf != 7'h0) begin
			fl = fl | setf;
			anyf = anyf | (|(fl & ier_q));
		end
		if (item.kind == K_WRITE && item.reg_offset == R_IER) anyf = |(fl & ier_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_a_q <= '0; dir_b_q <= '0; ora_q <= '0; orb_q <= '0;
			pins_a_q <= '0; pins_b_q <= '0; cin_q <= '0; cout_q <= '0;
			t1l_q <= '0; t1c_q <= '0; t2c_q <= '0; t1r_q <= 1'b0; t2r_q <= 1'b0;
			t2ll_q <= '0; sr_q <= '0; pcr_q <= '0; acr_q <= '0; ier_q <= '0;
			ifr_q <= '0;
		end else if (en) begin
			dir_a_q <= dir_a_d; dir_b_q <= dir_b_d; ora_q <= ora_d; orb_q <= orb_d;
			pins_a_q <= pins_a_d; pins_b_q <= pins_b_d; cin_q <= cin_d; cout_q <= cout_d;
			t1l_q <= t1l_d; t1c_q <= t1c_d; t2c_q <= t2c_d; t1r_q <= t1r_d; t2r_q <= t2r_d;
			t2ll_q <= t2ll_d; sr_q <= sr_d; pcr_q <= pcr_d; acr_q <= acr_d; ier_q <= ier_d;
			ifr_q <= {anyf, fl};
		end
	end

	always_comb begin
		res.read_data = rd;
		res.irq = anyf;
		res.port_a_out = (ora_d & dir_a_d) | ~dir_a_d;
		res.port_b_out = (orb_d & dir_b_d) | ~dir_b_d;
		res.ca2_level = cout_d[0];
		res.cb2_level = cout_d[1];
	end
endmodule

### sim/versatile_interface_adapter_tb.sv
// Self-checking testbench for the 6522-style interface adapter: bus accesses,
// timer ticks and pin updates are checked against a cycle-free predictor.
// Depends on via_pkg and the versatile_interface_adapter RTL.
module versatile_interface_adapter_tb;
	import via_pkg::*;

	typedef struct {
		item_t it;
		bit drain;
		int phase;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] kind = '0;
	logic [3:0] reg_offset = '0;
	logic [7:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_data;
	logic irq;
	logic [7:0] port_a_out;
	logic [7:0] port_b_out;
	logic ca2_level;
	logic cb2_level;

	versatile_interface_adapter u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted adapter state.
	logic [7:0] p_dir_a, p_dir_b, p_ora, p_orb, p_pins_a, p_pins_b;
	logic [7:0] p_pcr, p_acr, p_ifr, p_sr, p_t2_latch_lo;
	logic [6:0] p_ier;
	logic [3:0] p_ctl_in;
	logic [1:0] p_ctl_out;
	logic [15:0] p_t1_latch, p_t1_count, p_t2_count;
	bit p_t1_run, p_t2_run;

	pend_t pend_q[$];
	result_t result_q[$];
	int errors = 0, n_sent = 0, n_done = 0, n_irq = 0, gen_phase = 0, cur_phase = 0;
	int hold_left = 0, cycles = 0;
	bit hold_done = 0;

	function automatic void flag_raise(logic [6:0] f);
		p_ifr = p_ifr | {1'b0, f};
		if ((p_ifr[6:0] & p_ier) != 0)
			p_ifr[7] = 1'b1;
	endfunction

	function automatic void flag_clear(logic [7:0] f);
		p_ifr = p_ifr & ~f & 8'h7f;
		if ((p_ifr[6:0] & p_ier) != 0)
			p_ifr[7] = 1'b1;
	endfunction

	function automatic void clear_port_a_flags();
		flag_clear({1'b0, F_CA1 | (((p_pcr & 8'h0a) == 8'h02) ? 7'h00 : F_CA2)});
	endfunction

	function automatic void clear_port_b_flags();
		flag_clear({1'b0, F_CB1 | (((p_pcr & 8'ha0) == 8'h20) ? 7'h00 : F_CB2)});
	endfunction

	// Edge on CA1/CB1: the selected edge raises the flag and ends a handshake.
	function automatic void line1_edge(int b, bit lvl, bit rising, logic [6:0] f,
			bit hs, int ob);
		if (lvl != p_ctl_in[b]) begin
			if (lvl == rising) begin
				flag_raise(f);
				if (hs)
					p_ctl_out[ob] = 1'b1;
			end
			p_ctl_in[b] = lvl;
		end
	endfunction

	// Edge on CA2/CB2 used as input; mode holds the two PCR bits of the line.
	function automatic void line2_edge(int b, bit lvl, logic [1:0] mode, logic [6:0] f);
		if (mode[1] || lvl == p_ctl_in[b])
			return;
		if ((lvl && mode == 2'b01) || (!lvl && mode == 2'b00))
			flag_raise(f);
		p_ctl_in[b] = lvl;
	endfunction

	function automatic logic [7:0] reg_read(logic [3:0] off);
		logic [7:0] m;
		case (off)
			R_ORB: begin
				clear_port_b_flags();
				m = p_acr[7] ? (p_dir_b | 8'h80) : p_dir_b;
				return (p_orb & m) | (p_pins_b & ~m);
			end
			R_ORA: begin
				m = p_dir_a | (p_pins_a & ~p_dir_a);
				clear_port_a_flags();
				if ((p_pcr & 8'h0c) == 8'h08)
					p_ctl_out[0] = 1'b0;
				return m;
			end
			R_DDRB: return p_dir_b;
			R_DDRA: return p_dir_a;
			R_T1CL: begin
				flag_clear({1'b0, F_T1});
				return p_t1_count[7:0];
			end
			R_T1CH: return p_t1_count[15:8];
			R_T1LL: return p_t1_latch[7:0];
			R_T1LH: return p_t1_latch[15:8];
			R_T2CL: begin
				flag_clear({1'b0, F_T2});
				return p_t2_count[7:0];
			end
			R_T2CH: return p_t2_count[15:8];
			R_SR: return p_sr;
			R_ACR: return p_acr;
			R_PCR: return p_pcr;
			R_IFR: return p_ifr;
			R_IER: return {1'b1, p_ier};
			default: return p_dir_a | (p_pins_a & ~p_dir_a);
		endcase
	endfunction

	function automatic void reg_write(logic [3:0] off, logic [7:0] d);
		case (off)
			R_ORB: begin
				p_orb = p_acr[7] ? {p_orb[7], d[6:0]} : d;
				clear_port_b_flags();
				if ((p_pcr & 8'hc0) == 8'h80)
					p_ctl_out[1] = 1'b0;
			end
			R_ORA: begin
				p_ora = d;
				clear_port_a_flags();
				if ((p_pcr & 8'h0e) == 8'h0a)
					p_ctl_out[0] = 1'b1;
				else if ((p_pcr & 8'h0c) == 8'h08)
					p_ctl_out[0] = 1'b0;
			end
			R_DDRB: p_dir_b = d;
			R_DDRA: p_dir_a = d;
			R_T1CL, R_T1LL: p_t1_latch[7:0] = d;
			R_T1LH: begin
				p_t1_latch[15:8] = d;
				flag_clear({1'b0, F_T1});
			end
			R_T1CH: begin
				p_t1_latch[15:8] = d;
				p_t1_count = p_t1_latch;
				flag_clear({1'b0, F_T1});
				if (p_acr[7])
					p_orb[7] = 1'b0;
				p_t1_run = 1;
			end
			R_T2CL: p_t2_latch_lo = d;
			R_T2CH: begin
				p_t2_count = {d, p_t2_latch_lo};
				flag_clear({1'b0, F_T2});
				if (p_acr[5]) begin
					p_t2_run = 0;
				end else if (p_t2_count != 0) begin
					p_t2_run = 1;
				end else begin
					p_t2_run = 0;
					p_t2_count = 16'hffff;
				end
			end
			R_SR: p_sr = d;
			R_ACR: begin
				p_acr = d;
				if (d[7])
					p_orb[7] = !p_t1_run;
				if (d[6])
					p_t1_run = 1;
			end
			R_PCR: begin
				p_pcr = d;
				if (d[3:2] == 2'b11)
					p_ctl_out[0] = d[1];
				if (d[7:6] == 2'b11)
					p_ctl_out[1] = d[5];
			end
			R_IFR: flag_clear(d[7] ? 8'h7f : d);
			default: begin
				if (off == R_IER) begin
					p_ier = d[7] ? (p_ier | d[6:0]) : (p_ier & ~d[6:0]);
					p_ifr[7] = (p_ifr[6:0] & p_ier) != 0;
				end else begin
					p_ora = d;
				end
			end
		endcase
	endfunction

	function automatic void timer_tick();
		if (p_t1_run && p_t1_count <= 16'd1) begin
			if (p_acr[6]) begin
				if (p_acr[7])
					p_orb[7] = ~p_orb[7];
				p_t1_count = p_t1_latch;
			end else begin
				if (p_acr[7])
					p_orb[7] = 1'b1;
				p_t1_run = 0;
				p_t1_count = 16'hffff;
			end
			flag_raise(F_T1);
		end else begin
			p_t1_count = p_t1_count - 16'd1;
		end
		if (!p_acr[5]) begin
			if (p_t2_run && p_t2_count <= 16'd1) begin
				p_t2_run = 0;
				p_t2_count = 16'hffff;
				flag_raise(F_T2);
			end else begin
				p_t2_count = p_t2_count - 16'd1;
			end
		end
	endfunction

	// Advance the predicted adapter by one transfer and return its result.
	function automatic result_t adapter_step(item_t it);
		result_t r;
		logic [7:0] rd = 8'h00;
		bit lvl = it.value[0];
		case (it.kind)
			K_READ: rd = reg_read(it.reg_offset);
			K_WRITE: reg_write(it.reg_offset, it.value);
			K_TICK: timer_tick();
			K_PA: p_pins_a = it.value;
			K_PB: begin
				if (p_acr[5] && p_t2_count != 0 && p_pins_b[6] && !it.value[6]) begin
					p_t2_count = p_t2_count - 16'd1;
					if (p_t2_count == 0)
						flag_raise(F_T2);
				end
				p_pins_b = it.value;
			end
			K_CA1: line1_edge(0, lvl, p_pcr[0], F_CA1, p_pcr[3:2] == 2'b10, 0);
			K_CA2: line2_edge(1, lvl, p_pcr[3:2], F_CA2);
			K_CB1: line1_edge(2, lvl, p_pcr[4], F_CB1, p_pcr[7:6] == 2'b10, 1);
			K_CB2: line2_edge(3, lvl, p_pcr[7:6], F_CB2);
			default: ;
		endcase
		r.read_data = rd;
		r.irq = p_ifr[7];
		r.port_a_out = (p_ora & p_dir_a) | ~p_dir_a;
		r.port_b_out = (p_orb & p_dir_b) | ~p_dir_b;
		r.ca2_level = p_ctl_out[0];
		r.cb2_level = p_ctl_out[1];
		return r;
	endfunction

	function automatic int sender_gap(int ph);
		return (ph == 0) ? 13 : (ph == 1) ? 61 : 0;
	endfunction

	function automatic int receiver_gap(int ph);
		return (ph == 0) ? 61 : (ph == 1) ? 13 : 0;
	endfunction

	// Driver: offer the next pending item; a drain item waits for every result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				result_q.push_back(adapter_step({kind, reg_offset, value}));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() > 0 && (!pend_q[0].drain || result_q.size() == 0)
						&& $urandom_range(99) >= sender_gap(pend_q[0].phase)) begin
					kind <= pend_q[0].it.kind;
					reg_offset <= pend_q[0].it.reg_offset;
					value <= pend_q[0].it.value;
					cur_phase <= pend_q[0].phase;
					in_valid <= 1'b1;
					void'(pend_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here, so the block backs up into its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (n_sent >= 150 && !hold_done) begin
				hold_left <= 80;
				hold_done <= 1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	function automatic void field_check(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	result_t exp_r;

	// Monitor: compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result transfer, got read_data %0h",
						$time, read_data);
					errors++;
				end else begin
					exp_r = result_q.pop_front();
					field_check("read_data", exp_r.read_data, read_data);
					field_check("irq", exp_r.irq, irq);
					field_check("port_a_out", exp_r.port_a_out, port_a_out);
					field_check("port_b_out", exp_r.port_b_out, port_b_out);
					field_check("ca2_level", exp_r.ca2_level, ca2_level);
					field_check("cb2_level", exp_r.cb2_level, cb2_level);
					n_done++;
					n_irq += irq;
				end
			end
			out_stall <= (hold_left > 1) || ($urandom_range(99) < receiver_gap(cur_phase));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				result_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void add(int k, int off, int v);
		pend_t e;
		e.it = '{kind: k[3:0], reg_offset: off[3:0], value: v[7:0]};
		e.drain = 0;
		e.phase = gen_phase;
		pend_q.push_back(e);
	endfunction

	// Timer sequence: short counts so that both timers expire under ticks.
	function automatic void timer_burst();
		add(K_WRITE, R_ACR, $urandom_range(255) & 8'hdf);
		add(K_WRITE, R_IER, $urandom_range(255));
		add(K_WRITE, R_DDRB, $urandom_range(255));
		add(K_WRITE, R_T1LL, $urandom_range(6));
		add(K_WRITE, R_T1CH, ($urandom_range(7) == 0) ? $urandom_range(255) : 0);
		add(K_WRITE, R_T2CL, $urandom_range(8));
		add(K_WRITE, R_T2CH, ($urandom_range(7) == 0) ? $urandom_range(255) : 0);
		repeat ($urandom_range(1, 12))
			add(K_TICK, $urandom_range(15), $urandom_range(255));
		add(K_READ, R_IFR, 0);
		add(K_READ, $urandom_range(1) ? R_T1CL : R_T2CL, 0);
		add(K_READ, R_ORB, 0);
	endfunction

	// Pulse counting on PB6.
	function automatic void pb6_burst();
		add(K_WRITE, R_ACR, 8'h20 | ($urandom_range(255) & 8'h1f));
		add(K_WRITE, R_T2CL, $urandom_range(3));
		add(K_WRITE, R_T2CH, 0);
		repeat ($urandom_range(2, 8)) begin
			add(K_PB, R_ORB, 8'h40 | $urandom_range(255));
			add(K_PB, R_ORB, 8'hbf & $urandom_range(255));
		end
		add(K_READ, R_T2CL, 0);
		add(K_READ, R_IFR, 0);
	endfunction

	// Handshake lines: random PCR, then port accesses and control line edges.
	function automatic void handshake_burst();
		add(K_WRITE, R_PCR, $urandom_range(255));
		add(K_WRITE, R_DDRA, $urandom_range(255));
		add(K_WRITE, R_ORA, $urandom_range(255));
		repeat ($urandom_range(2, 6))
			add($urandom_range(K_PA, K_CB2), $urandom_range(15), $urandom_range(255));
		add(K_READ, $urandom_range(1) ? R_ORA : R_ORB, 0);
		add(K_WRITE, R_ORB, $urandom_range(255));
		add(K_READ, R_IFR, 0);
	endfunction

	int total;

	initial begin
		// Start the predictor from the reset state.
		p_dir_a = '0; p_dir_b = '0; p_ora = '0; p_orb = '0;
		p_pins_a = '0; p_pins_b = '0;
		p_pcr = '0; p_acr = '0; p_ifr = '0; p_sr = '0; p_t2_latch_lo = '0;
		p_ier = '0; p_ctl_in = '0; p_ctl_out = '0;
		p_t1_latch = '0; p_t1_count = '0; p_t2_count = '0;
		p_t1_run = 0; p_t2_run = 0;
		gen_phase = 0;
		// Directed: ports, one-shot and continuous T1, zero T2 start, PB6 counting,
		// pulse and fixed CA2 outputs, unknown kinds, global IFR clear.
		add(K_WRITE, R_DDRA, 8'hff);
		add(K_WRITE, R_ORA, 8'h55);
		add(K_PA, R_ORB, 8'haa);
		add(K_READ, R_ORA, 0);
		add(K_READ, R_ORANH, 0);
		add(K_WRITE, R_IER, 8'hff);
		add(K_WRITE, R_T1LL, 8'h02);
		add(K_WRITE, R_T1CH, 8'h00);
		repeat (3) add(K_TICK, R_ORB, 0);
		add(K_READ, R_IFR, 0);
		add(K_WRITE, R_ACR, 8'hc0);
		add(K_WRITE, R_DDRB, 8'hff);
		repeat (4) add(K_TICK, R_ORB, 0);
		add(K_WRITE, R_T2CL, 8'h00);
		add(K_WRITE, R_T2CH, 8'h00);
		add(K_WRITE, R_ACR, 8'h20);
		add(K_WRITE, R_T2CL, 8'h01);
		add(K_WRITE, R_T2CH, 8'h00);
		add(K_PB, R_ORB, 8'hff);
		add(K_PB, R_ORB, 8'h00);
		add(K_WRITE, R_PCR, 8'h0a);
		add(K_WRITE, R_ORA, 8'hff);
		add(K_CA1, R_ORB, 8'h01);
		add(K_WRITE, R_PCR, 8'hee);
		add(K_CA2, R_ORB, 8'h01);
		add(K_WRITE, R_SR, 8'hff);
		add(K_READ, R_SR, 0);
		add(4'd9, R_ORB, 8'hff);
		add(4'd15, R_ORANH, 8'hff);
		add(K_WRITE, R_IFR, 8'h80);

		total = 540;
		while (pend_q.size() < total) begin
			gen_phase = pend_q.size() * 3 / total;
			case ($urandom_range(9))
				0, 1: timer_burst();
				2: pb6_burst();
				3, 4: handshake_burst();
				default: add($urandom_range(15), $urandom_range(15), $urandom_range(255));
			endcase
		end
		// Pause the sender once until every outstanding result has drained.
		pend_q[300].drain = 1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_q.size() == 0 && !in_valid);
		wait (result_q.size() == 0);
		repeat (20) @(posedge clk);
		$display("%0d transfers checked over three idling profiles, %0d with irq set",
			n_done, n_irq);
		if (errors == 0 && result_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
